FILE: rtl/bqeq_pkg.sv
// ----------------------------------------------------------------------------
// bqeq_pkg - shared types and constants of the biquad peaking EQ cascade
// Item formats, register and coefficient codes, fixed-point constants and the
// control bundle of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bqeq_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

    localparam logic       FILTER_ENABLE_RESET = 1'b1;
    localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;
    localparam int         NUM_COEFS = 5;

    localparam int COEF_FRAC = 28;
    localparam int SIG_FRAC  = 26;
    localparam int IN_SHIFT  = 11;

    localparam logic [14:0] OUT_SCALE = 15'd32767;

    typedef struct packed {
        logic               operation;
        logic               channel;
        logic signed [15:0] sample_in;
        logic        [3:0]  band_index;
        logic        [2:0]  coef_index;
        logic signed [31:0] coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               clipped;
    } out_item_t;

    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
        logic clear;
        logic negate;
    } mac_ctrl_t;

endpackage

FILE: rtl/bqeq_ram.sv
// ----------------------------------------------------------------------------
// bqeq_ram - single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bqeq_ram #(
    parameter int  DEPTH = 55,
    parameter int  WIDTH = 33,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bqeq_mac.sv
// ----------------------------------------------------------------------------
// bqeq_mac - shared sign-magnitude multiply-accumulate unit
// Two half-width partial products, Q28 rescale with magnitude clamp, then a
// signed accumulate. Sum and accumulate each register the cycle after its input.
// ----------------------------------------------------------------------------
module bqeq_mac #(
    parameter int CMW = 32,
    parameter int SW  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bqeq_pkg::mac_ctrl_t ctrl,
    input  logic [CMW-1:0]      mc,
    input  logic [SW-1:0]       ms,
    output logic [SW+2:0]       acc
);

    localparam int H   = SW / 2;
    localparam int HW  = SW - H;
    localparam int PW  = CMW + SW;
    localparam int SHW = PW - bqeq_pkg::COEF_FRAC;
    localparam int AW  = SW + 3;
    localparam logic [SHW-1:0] LIMIT = SHW'(1) << (SW - 1);

    logic [CMW+H-1:0]  plo_reg;
    logic [CMW+HW-1:0] phi_reg;
    logic              sum_pend_reg;
    logic              neg_s_reg;
    logic [SW-1:0]     mag_reg;
    logic              acc_pend_reg;
    logic              neg_a_reg;
    logic [AW-1:0]     acc_reg;

    logic [PW-1:0]  prod;
    logic [SHW-1:0] shifted;
    logic [AW-1:0]  mag_ext;

    assign prod    = {phi_reg, {H{1'b0}}} + PW'(plo_reg);
    assign shifted = prod[PW-1:bqeq_pkg::COEF_FRAC];
    assign mag_ext = AW'(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_pend_reg <= 1'b0;
            acc_pend_reg <= 1'b0;
        end
        else
        begin
            sum_pend_reg <= ctrl.mul_hi;
            acc_pend_reg <= sum_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_lo)
        begin
            plo_reg <= mc * ms[H-1:0];
        end
        if (ctrl.mul_hi)
        begin
            phi_reg   <= mc * ms[SW-1:H];
            neg_s_reg <= ctrl.negate;
        end
        if (sum_pend_reg)
        begin
            mag_reg   <= (shifted > LIMIT) ? LIMIT[SW-1:0] : shifted[SW-1:0];
            neg_a_reg <= neg_s_reg;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (acc_pend_reg)
        begin
            acc_reg <= neg_a_reg ? (acc_reg - mag_ext) : (acc_reg + mag_ext);
        end
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/biquad_peaking_eq_cascade_unit.sv
// ----------------------------------------------------------------------------
// biquad_peaking_eq_cascade_unit - cascade of Direct Form I biquad sections
// Stereo peaking EQ: NUM_BANDS biquads in series, one shared MAC unit.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready as in_data. A sample item (operation
// 0) runs through all bands and yields one result on out_valid/out_ready. A
// coefficient item (operation 1) with in-range indexes writes one coefficient,
// clears that band's history and yields no result. Config writes (cfg_write)
// set filter_enable and channel_count; the user must issue them only while the
// block is idle, which the block itself does not enforce.
// Per band, a filtered sample passes S_BAND (read), low and high multiplier
// states for each of the five terms, the S_TAIL1 and S_TAIL2 drain states and
// S_FIN (clamp and history write); after the last band, S_CONV converts the
// output and S_DONE hands it off. The block takes one item at a time: in_ready
// is high only in S_IDLE, which it passes through before the next accept. A
// bypassed sample goes straight to S_DONE; a coefficient write stays in S_IDLE.
// Reset restores identity coefficients, zero history, filter enabled and
// stereo mode at once through per-entry and per-row valid bits; no clearing
// pass is needed. A result waits in the output register while out_ready is
// low; the next item is still accepted and its result holds in the sequencer
// until the output register frees up.
// ----------------------------------------------------------------------------
module biquad_peaking_eq_cascade_unit #(
    parameter int NUM_BANDS    = 11,
    parameter int NUM_CHANNELS = 2,
    parameter int COEF_WIDTH   = 32,
    parameter int SIGNAL_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bqeq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bqeq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bqeq_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bqeq_pkg::out_item_t                out_data
);

    localparam int SW     = SIGNAL_WIDTH;
    localparam int CMW    = (COEF_WIDTH > 29) ? COEF_WIDTH : 29;
    localparam int CE_W   = CMW + 1;
    localparam int HE_W   = SW + 1;
    localparam int HR_W   = 4 * HE_W;
    localparam int AW     = SW + 3;
    localparam int CDEPTH = NUM_BANDS * bqeq_pkg::NUM_COEFS;
    localparam int HDEPTH = NUM_BANDS * NUM_CHANNELS;
    localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int ROW_W  = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    localparam logic [63:0] SIG_LIM64 = 64'd1 << (SW - 1);
    localparam logic [63:0] SIG_MAX64 = SIG_LIM64 - 64'd1;
    localparam logic [63:0] ONE_OUT64 = 64'd1 << bqeq_pkg::SIG_FRAC;
    localparam logic signed [63:0] CF_MAX = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] CF_MIN = -CF_MAX - 64'sd1;
    localparam logic [CMW-1:0] COEF_ONE = CMW'(64'd1 << bqeq_pkg::COEF_FRAC);
    localparam logic [AW-1:0]  NEG_LIM  = AW'(1) << (SW - 1);
    localparam logic [AW-1:0]  POS_LIM  = NEG_LIM - AW'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BAND,
        S_MLO,
        S_MHI,
        S_TAIL1,
        S_TAIL2,
        S_FIN,
        S_CONV,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [2:0]          term_reg;
    logic [CA_W-1:0]     coef_base_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                x_sign_reg;
    logic [SW-1:0]       x_mag_reg;
    logic                coef_vq_reg;
    logic                hist_vq_reg;
    logic [15:0]         res_reg;
    logic                clip_reg;
    logic                out_valid_reg;
    bqeq_pkg::out_item_t out_data_reg;
    logic                filter_enable_reg;
    logic [1:0]          chan_cnt_reg;
    logic [CDEPTH-1:0]   coef_vld_reg;
    logic [HDEPTH-1:0]   hist_vld_reg;

    // input conversion and coefficient formatting
    logic        accept;
    logic [16:0] s_ext;
    logic [16:0] s_abs;
    logic [63:0] x_scaled;
    logic [63:0] x_lim;
    logic [SW-1:0] x_mag_in;
    logic signed [63:0] cv;
    logic signed [63:0] csat;
    logic [63:0] cmag;
    logic        coef_ok;
    logic        coef_we;
    logic [CA_W-1:0] coef_waddr;

    // memory ports
    logic            coef_re;
    logic [CA_W-1:0] coef_raddr;
    logic [CE_W-1:0] coef_rdata;
    logic            hist_re;
    logic            hist_we;
    logic [HR_W-1:0] hist_rdata;
    logic [HR_W-1:0] hist_wdata;

    // operands
    logic            c_sign;
    logic [CMW-1:0]  c_mag;
    logic [HR_W-1:0] hv;
    logic [HE_W-1:0] x1_op;
    logic [HE_W-1:0] x2_op;
    logic [HE_W-1:0] y1_op;
    logic [HE_W-1:0] y2_op;
    logic [HE_W-1:0] s_op;
    logic            sub_term;
    bqeq_pkg::mac_ctrl_t mac_ctrl;
    logic [AW-1:0]   acc;

    // band result
    logic            acc_neg;
    logic [AW-1:0]   neg_acc;
    logic [SW-1:0]   y_mag;

    // output conversion
    logic [63:0] fin_ext;
    logic [41:0] scaled_prod;
    logic [15:0] m_out;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        s_ext    = {in_data.sample_in[15], in_data.sample_in};
        s_abs    = s_ext[16] ? (17'd0 - s_ext) : s_ext;
        x_scaled = 64'(s_abs) << bqeq_pkg::IN_SHIFT;
        x_lim    = s_ext[16] ? SIG_LIM64 : SIG_MAX64;
        x_mag_in = (x_scaled > x_lim) ? x_lim[SW-1:0] : x_scaled[SW-1:0];

        cv   = 64'($signed(in_data.coef_value));
        csat = (cv > CF_MAX) ? CF_MAX : ((cv < CF_MIN) ? CF_MIN : cv);
        cmag = csat[63] ? (64'd0 - csat) : csat;

        coef_ok    = (int'(in_data.band_index) < NUM_BANDS) &&
                     (in_data.coef_index <= bqeq_pkg::COEF_A2);
        coef_we    = accept && (in_data.operation == bqeq_pkg::OP_COEF) && coef_ok;
        coef_waddr = CA_W'(int'(in_data.band_index) * bqeq_pkg::NUM_COEFS +
                           int'(in_data.coef_index));
    end

    assign coef_re    = (state_reg == S_BAND) ||
                        ((state_reg == S_MHI) && (term_reg != bqeq_pkg::COEF_A2));
    assign coef_raddr = coef_base_reg + CA_W'(term_reg) +
                        ((state_reg == S_MHI) ? CA_W'(1) : CA_W'(0));
    assign hist_re    = (state_reg == S_BAND);
    assign hist_we    = (state_reg == S_FIN);

    bqeq_ram #(
        .DEPTH (CDEPTH),
        .WIDTH (CE_W)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata ({csat[63], cmag[CMW-1:0]}),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqeq_ram #(
        .DEPTH (HDEPTH),
        .WIDTH (HR_W)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (row_reg),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (row_reg),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        if (coef_vq_reg)
        begin
            c_sign = coef_rdata[CE_W-1];
            c_mag  = coef_rdata[CMW-1:0];
        end
        else if (term_reg == bqeq_pkg::COEF_B0)
        begin
            c_sign = 1'b0;
            c_mag  = COEF_ONE;
        end
        else
        begin
            c_sign = 1'b0;
            c_mag  = '0;
        end

        hv    = hist_vq_reg ? hist_rdata : '0;
        x1_op = hv[HR_W-1 -: HE_W];
        x2_op = hv[HR_W-HE_W-1 -: HE_W];
        y1_op = hv[2*HE_W-1 -: HE_W];
        y2_op = hv[HE_W-1 -: HE_W];

        case (term_reg)
            bqeq_pkg::COEF_B0: s_op = {x_sign_reg, x_mag_reg};
            bqeq_pkg::COEF_B1: s_op = x1_op;
            bqeq_pkg::COEF_B2: s_op = x2_op;
            bqeq_pkg::COEF_A1: s_op = y1_op;
            bqeq_pkg::COEF_A2: s_op = y2_op;
            default:           s_op = '0;
        endcase

        sub_term = (term_reg == bqeq_pkg::COEF_A1) || (term_reg == bqeq_pkg::COEF_A2);

        mac_ctrl.mul_lo = (state_reg == S_MLO);
        mac_ctrl.mul_hi = (state_reg == S_MHI);
        mac_ctrl.clear  = (state_reg == S_BAND);
        mac_ctrl.negate = c_sign ^ s_op[HE_W-1] ^ sub_term;
    end

    bqeq_mac #(
        .CMW (CMW),
        .SW  (SW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .mc    (c_mag),
        .ms    (s_op[SW-1:0]),
        .acc   (acc)
    );

    // clamp the band sum to the signal range, in sign-magnitude form
    always_comb
    begin
        acc_neg = acc[AW-1];
        neg_acc = AW'(0) - acc;
        if (acc_neg)
        begin
            y_mag = (neg_acc > NEG_LIM) ? NEG_LIM[SW-1:0] : neg_acc[SW-1:0];
        end
        else
        begin
            y_mag = (acc > POS_LIM) ? POS_LIM[SW-1:0] : acc[SW-1:0];
        end
        hist_wdata = {x_sign_reg, x_mag_reg, x1_op, acc_neg, y_mag, y1_op};
    end

    always_comb
    begin
        fin_ext     = 64'(x_mag_reg);
        scaled_prod = 42'(fin_ext[26:0]) * 42'(bqeq_pkg::OUT_SCALE);
        m_out       = scaled_prod[41:26];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= bqeq_pkg::FILTER_ENABLE_RESET;
            chan_cnt_reg      <= bqeq_pkg::CHANNEL_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bqeq_pkg::REG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                bqeq_pkg::REG_CHANNEL_COUNT: chan_cnt_reg      <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
                for (int r = 0; r < HDEPTH; r++)
                begin
                    if (int'(in_data.band_index) == r / NUM_CHANNELS)
                    begin
                        hist_vld_reg[r] <= 1'b0;
                    end
                end
            end
            else if (hist_we)
            begin
                hist_vld_reg[row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (coef_re)
            begin
                coef_vq_reg <= coef_vld_reg[coef_raddr];
            end
            if (hist_re)
            begin
                hist_vq_reg <= hist_vld_reg[row_reg];
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (in_data.operation == bqeq_pkg::OP_SAMPLE))
                    begin
                        if (!filter_enable_reg)
                        begin
                            res_reg   <= in_data.sample_in;
                            clip_reg  <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            x_sign_reg    <= s_ext[16];
                            x_mag_reg     <= x_mag_in;
                            band_reg      <= '0;
                            coef_base_reg <= '0;
                            term_reg      <= bqeq_pkg::COEF_B0;
                            if ((chan_cnt_reg <= 2'd1) || (NUM_CHANNELS == 1))
                            begin
                                row_reg <= '0;
                            end
                            else
                            begin
                                row_reg <= ROW_W'(in_data.channel);
                            end
                            state_reg <= S_BAND;
                        end
                    end
                end
                S_BAND:
                begin
                    term_reg  <= bqeq_pkg::COEF_B0;
                    state_reg <= S_MLO;
                end
                S_MLO:
                begin
                    state_reg <= S_MHI;
                end
                S_MHI:
                begin
                    if (term_reg == bqeq_pkg::COEF_A2)
                    begin
                        state_reg <= S_TAIL1;
                    end
                    else
                    begin
                        term_reg  <= term_reg + 3'd1;
                        state_reg <= S_MLO;
                    end
                end
                S_TAIL1:
                begin
                    state_reg <= S_TAIL2;
                end
                S_TAIL2:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    x_sign_reg <= acc_neg;
                    x_mag_reg  <= y_mag;
                    if (band_reg == BAND_W'(NUM_BANDS - 1))
                    begin
                        state_reg <= S_CONV;
                    end
                    else
                    begin
                        band_reg      <= band_reg + BAND_W'(1);
                        coef_base_reg <= coef_base_reg + CA_W'(bqeq_pkg::NUM_COEFS);
                        row_reg       <= row_reg + ROW_W'(NUM_CHANNELS);
                        term_reg      <= bqeq_pkg::COEF_B0;
                        state_reg     <= S_BAND;
                    end
                end
                S_CONV:
                begin
                    if (fin_ext > ONE_OUT64)
                    begin
                        res_reg  <= x_sign_reg ? 16'h8000 : 16'h7FFF;
                        clip_reg <= 1'b1;
                    end
                    else
                    begin
                        res_reg  <= x_sign_reg ? (16'd0 - m_out) : m_out;
                        clip_reg <= 1'b0;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_data_reg.sample_out <= res_reg;
                        out_data_reg.clipped    <= clip_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/biquad_peaking_eq_cascade_unit_test.sv
// ----------------------------------------------------------------------------
// biquad_peaking_eq_cascade_unit_test - self-checking bench for the EQ cascade
// Streams sample and coefficient items through the block under random
// handshake gaps and compares each result against a bit-exact fixed-point
// model of the eleven-band Direct Form I cascade. It steps through filtered,
// bypassed, mono and stereo settings.
// ----------------------------------------------------------------------------
module biquad_peaking_eq_cascade_unit_test;
    import bqeq_pkg::*;

    localparam int     NB            = 11;
    localparam int     NCH           = 2;
    localparam int     HALF_PERIOD   = 6;
    localparam int     CYCLE_LIMIT   = 2000000;
    localparam int     SETTLE_CYCLES = 200;
    localparam int     LONG_HOLD     = 2000;
    localparam int     PHASE_ITEMS   = 200;
    localparam longint ONE_Q28       = 64'd1 << COEF_FRAC;
    localparam longint SIG_ONE       = 64'd1 << SIG_FRAC;
    localparam longint SIG_MAX       = 64'd2147483647;
    localparam longint SIG_MIN       = -64'sd2147483648;
    localparam longint A2_SPAN       = 250000000;
    localparam longint B_SPAN        = 64'd1 << 27;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    logic                  calm        = 1'b0;
    logic                  hold_output = 1'b0;
    int                    cycle_count = 0;

    biquad_peaking_eq_cascade_unit #(
        .NUM_BANDS    (NB),
        .NUM_CHANNELS (NCH),
        .COEF_WIDTH   (32),
        .SIGNAL_WIDTH (32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    class eq_scoreboard;
        longint     coef   [NB][NUM_COEFS];
        longint     x_hist [NB][NCH][2];
        longint     y_hist [NB][NCH][2];
        logic       enable;
        logic [1:0] chan_count;
        out_item_t  expected_samples [$];
        int         errors;

        function new();
            for (int b = 0; b < NB; b++)
            begin
                for (int k = 0; k < NUM_COEFS; k++)
                    coef[b][k] = 0;
                coef[b][COEF_B0] = ONE_Q28;
                clear_band(b);
            end
            enable     = FILTER_ENABLE_RESET;
            chan_count = CHANNEL_COUNT_RESET;
            errors     = 0;
        endfunction

        function void clear_band(int b);
            for (int c = 0; c < NCH; c++)
            begin
                for (int t = 0; t < 2; t++)
                begin
                    x_hist[b][c][t] = 0;
                    y_hist[b][c][t] = 0;
                end
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FILTER_ENABLE)
                enable = data[0];
            else
                chan_count = data[1:0];
        endfunction

        function longint sat_signal(longint v);
            if (v > SIG_MAX)
                return SIG_MAX;
            if (v < SIG_MIN)
                return SIG_MIN;
            return v;
        endfunction

        // sign * floor(|c|*|s| / 2^28), magnitude capped at 2^31
        function longint scaled_product(longint c, longint s);
            longint unsigned mc;
            longint unsigned ms;
            longint unsigned mag;
            mc  = (c < 0) ? -c : c;
            ms  = (s < 0) ? -s : s;
            mag = (mc * ms) >> COEF_FRAC;
            if (mag > 64'd2147483648)
                mag = 64'd2147483648;
            return ((c < 0) != (s < 0)) ? -longint'(mag) : longint'(mag);
        endfunction

        function void note_item(in_item_t item);
            longint    x;
            longint    y;
            longint    acc;
            longint    mag;
            int        ch;
            out_item_t want;
            if (item.operation == OP_COEF)
            begin
                if (item.band_index < NB && item.coef_index < NUM_COEFS)
                begin
                    coef[item.band_index][item.coef_index] = longint'(item.coef_value);
                    clear_band(int'(item.band_index));
                end
                return;
            end
            if (!enable)
            begin
                want.sample_out = item.sample_in;
                want.clipped    = 1'b0;
                expected_samples.push_back(want);
                return;
            end
            ch = (chan_count <= 2'd1) ? 0 : int'(item.channel);
            x  = sat_signal(longint'(item.sample_in) * 2048);
            for (int b = 0; b < NB; b++)
            begin
                acc = scaled_product(coef[b][COEF_B0], x)
                    + scaled_product(coef[b][COEF_B1], x_hist[b][ch][0])
                    + scaled_product(coef[b][COEF_B2], x_hist[b][ch][1])
                    - scaled_product(coef[b][COEF_A1], y_hist[b][ch][0])
                    - scaled_product(coef[b][COEF_A2], y_hist[b][ch][1]);
                y = sat_signal(acc);
                x_hist[b][ch][1] = x_hist[b][ch][0];
                x_hist[b][ch][0] = x;
                y_hist[b][ch][1] = y_hist[b][ch][0];
                y_hist[b][ch][0] = y;
                x = y;
            end
            if (x > SIG_ONE)
            begin
                want.sample_out = 16'sh7FFF;
                want.clipped    = 1'b1;
            end
            else if (x < -SIG_ONE)
            begin
                want.sample_out = 16'sh8000;
                want.clipped    = 1'b1;
            end
            else
            begin
                mag = (((x < 0) ? -x : x) * 32767) >>> SIG_FRAC;
                want.sample_out = 16'((x < 0) ? -mag : mag);
                want.clipped    = 1'b0;
            end
            expected_samples.push_back(want);
        endfunction

        function void check_sample(out_item_t got);
            out_item_t want;
            if (expected_samples.size() == 0)
            begin
                $error("unexpected result: sample_out %0d clipped %0b",
                       got.sample_out, got.clipped);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got.sample_out !== want.sample_out)
            begin
                $error("sample_out: expected %0d, actual %0d", want.sample_out, got.sample_out);
                errors++;
            end
            if (got.clipped !== want.clipped)
            begin
                $error("clipped: expected %0b, actual %0b", want.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    eq_scoreboard sb;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic longint rand_span(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic in_item_t make_sample(logic ch, logic signed [15:0] s);
        logic [63:0] r;
        in_item_t    item;
        r         = {$urandom, $urandom};
        item      = r[$bits(in_item_t)-1:0];
        item.operation = OP_SAMPLE;
        item.channel   = ch;
        item.sample_in = s;
        return item;
    endfunction

    function automatic in_item_t make_coef(logic [3:0] band, logic [2:0] ci,
                                           logic signed [31:0] v);
        logic [63:0] r;
        in_item_t    item;
        r         = {$urandom, $urandom};
        item      = r[$bits(in_item_t)-1:0];
        item.operation  = OP_COEF;
        item.band_index = band;
        item.coef_index = ci;
        item.coef_value = v;
        return item;
    endfunction

    task automatic send_item(in_item_t item);
        int bursts;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 30) : 1;
            in_valid <= 1'b0;
            repeat (bursts) repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(item);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // mostly samples; stable whole-band retunes, lone and bad-index writes
    task automatic run_phase(int n_items);
        int                 done;
        int                 pick;
        logic [3:0]         band;
        longint             a1;
        longint             a2;
        logic signed [15:0] s;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                band = 4'($urandom_range(0, NB - 1));
                a2   = rand_span(A2_SPAN);
                a1   = rand_span(((ONE_Q28 + a2) * 15) / 16);
                send_item(make_coef(band, COEF_B0, 32'(ONE_Q28 + rand_span(B_SPAN))));
                send_item(make_coef(band, COEF_B1, 32'(rand_span(B_SPAN))));
                send_item(make_coef(band, COEF_B2, 32'(rand_span(B_SPAN))));
                send_item(make_coef(band, COEF_A1, 32'(a1)));
                send_item(make_coef(band, COEF_A2, 32'(a2)));
                done += 5;
            end
            else if (pick < 10)
            begin
                if ($urandom_range(0, 1))
                    send_item(make_coef(4'($urandom_range(NB, 15)), 3'($urandom), $urandom));
                else
                    send_item(make_coef(4'($urandom_range(0, NB - 1)),
                                        3'($urandom_range(5, 7)), $urandom));
            end
            else if (pick < 12)
            begin
                send_item(make_coef(4'($urandom_range(0, NB - 1)),
                                    3'($urandom_range(0, NUM_COEFS - 1)), $urandom));
                done++;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: s = 16'sh7FFF;
                    1: s = 16'sh8000;
                    2, 3, 4: s = 16'($urandom);
                    default: s = 16'(rand_span(4096));
                endcase
                send_item(make_sample(1'($urandom), s));
                done++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_sample(out_data);
    end

    initial
    begin : result_sink
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("biquad_peaking_eq_cascade_unit_test NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity cascade at the sample extremes
        send_item(make_sample(1'b0, 16'sh7FFF));
        send_item(make_sample(1'b1, 16'sh8000));
        send_item(make_sample(1'b0, 16'sh0000));
        send_item(make_sample(1'b1, -16'sd1));
        // extreme gains drive the output into saturation
        send_item(make_coef(4'd0, COEF_B0, 32'sh7FFFFFFF));
        send_item(make_sample(1'b0, 16'sh7FFF));
        send_item(make_sample(1'b0, 16'sh8000));
        send_item(make_coef(4'd0, COEF_B0, 32'sh80000000));
        send_item(make_sample(1'b1, 16'sd12345));
        // out-of-range band and coefficient indexes are ignored
        send_item(make_coef(4'd11, COEF_B0, 32'sh00000000));
        send_item(make_coef(4'd15, 3'd7, 32'sh12345678));
        send_item(make_coef(4'd3, 3'd5, 32'sh7FFFFFFF));
        send_item(make_sample(1'b1, 16'sd1000));
        send_item(make_coef(4'd0, COEF_B0, 32'(ONE_Q28)));
        send_item(make_coef(4'd10, COEF_A1, 32'(-(ONE_Q28 / 2))));
        send_item(make_coef(4'd10, COEF_A2, 32'(ONE_Q28 / 4)));
        send_item(make_coef(4'd5, COEF_B1, 32'(ONE_Q28 / 2)));
        send_item(make_coef(4'd5, COEF_B2, 32'(-(ONE_Q28 / 4))));
        send_item(make_sample(1'b0, 16'sd20000));
        send_item(make_sample(1'b1, -16'sd20000));
        send_item(make_sample(1'b0, 16'sd5));
        send_item(make_sample(1'b1, 16'sd5));

        run_phase(40);
        hold_output = 1'b1;
        run_phase(PHASE_ITEMS - 40);

        write_reg(REG_CHANNEL_COUNT, 2'd1);
        run_phase(PHASE_ITEMS);

        write_reg(REG_FILTER_ENABLE, 2'd0);
        run_phase(PHASE_ITEMS);

        write_reg(REG_FILTER_ENABLE, 2'd1);
        write_reg(REG_CHANNEL_COUNT, 2'd0);
        run_phase(PHASE_ITEMS);

        write_reg(REG_CHANNEL_COUNT, 2'd3);
        run_phase(PHASE_ITEMS);

        write_reg(REG_CHANNEL_COUNT, 2'd2);
        calm = 1'b1;
        run_phase(PHASE_ITEMS);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.expected_samples.size() != 0)
        begin
            $error("%0d results never arrived", sb.expected_samples.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("biquad_peaking_eq_cascade_unit_test OK");
        else
            $display("biquad_peaking_eq_cascade_unit_test NOT OK");
        $finish;
    end
endmodule

FILE: biquad_peaking_eq_cascade_unit.f
rtl/bqeq_pkg.sv
rtl/bqeq_ram.sv
rtl/bqeq_mac.sv
rtl/biquad_peaking_eq_cascade_unit.sv
tb/biquad_peaking_eq_cascade_unit_test.sv
